FILE: hdl/opm_pkg.sv
// Shared types, codes and defaults of the obstacle point memory.
`default_nettype none
package opm_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int MAX_ZONES_DEF   = 8;
   localparam int ROBOT_SLOTS_DEF = 4;

   // Request modes.
   localparam logic [2:0] MODE_DETECT = 3'd0;
   localparam logic [2:0] MODE_POSE   = 3'd1;
   localparam logic [2:0] MODE_ZONE   = 3'd2;
   localparam logic [2:0] MODE_EXPIRE = 3'd3;
   localparam logic [2:0] MODE_CLEAR  = 3'd4;

   // Response status codes.
   localparam logic [2:0] ST_STORED  = 3'd0;
   localparam logic [2:0] ST_REFRESH = 3'd1;
   localparam logic [2:0] ST_IN_ZONE = 3'd2;
   localparam logic [2:0] ST_NEAR    = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;
   localparam logic [2:0] ST_BOUNDS  = 3'd6;

   // Register indexes.
   localparam logic [2:0] REG_SELF_ID  = 3'd0;
   localparam logic [2:0] REG_LIFESPAN = 3'd1;
   localparam logic [2:0] REG_MARGIN   = 3'd2;
   localparam logic [2:0] REG_ZONES    = 3'd3;
   localparam logic [2:0] REG_DUP_RAD  = 3'd4;
   localparam logic [2:0] REG_ROB_RAD  = 3'd5;

   // Register reset values.
   localparam logic [2:0]  SELF_ID_RST  = 3'd1;
   localparam logic [15:0] LIFESPAN_RST = 16'd5000;
   localparam logic [10:0] MARGIN_RST   = 11'd250;
   localparam logic [3:0]  ZONES_RST    = 4'd0;
   localparam logic [9:0]  DUP_RAD_RST  = 10'd75;
   localparam logic [9:0]  ROB_RAD_RST  = 10'd100;

   // Table write data sources.
   localparam logic [1:0] WR_ITEM    = 2'd0;
   localparam logic [1:0] WR_REFRESH = 2'd1;
   localparam logic [1:0] WR_COPY    = 2'd2;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [31:0] seen;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       bounds_clr;
      logic       sq_go;
      logic       sq_mem;
      logic       exec;
      logic       mem_rd;
      logic       mem_we;
      logic [1:0] wr_src;
      logic       append;
      logic       set_total;
      logic       bounds_upd;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic zone_hit;
      logic near;
      logic dup_hit;
      logic keep;
   } stat_type;

endpackage
`default_nettype wire

FILE: hdl/opm_if.sv
// Request, response and register write channels of the obstacle point memory.
`default_nettype none
interface opm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [15:0] corner_x;
   logic [15:0] corner_y;
   logic [2:0]  robot_index;
   logic [2:0]  zone_index;
   logic [31:0] time_now;
   modport source (output valid, mode, pos_x, pos_y, corner_x, corner_y, robot_index,
                   zone_index, time_now, input ready);
   modport sink (input valid, mode, pos_x, pos_y, corner_x, corner_y, robot_index,
                 zone_index, time_now, output ready);
endinterface

interface opm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [6:0]  entry_count;
   logic        bounds_valid;
   logic [16:0] bound_min_x;
   logic [16:0] bound_min_y;
   logic [16:0] bound_max_x;
   logic [16:0] bound_max_y;
   modport source (output valid, status, entry_count, bounds_valid, bound_min_x,
                   bound_min_y, bound_max_x, bound_max_y, input ready);
   modport sink (input valid, status, entry_count, bounds_valid, bound_min_x,
                 bound_min_y, bound_max_x, bound_max_y, output ready);
endinterface

interface opm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/opm_dp.sv
// Datapath: registers, poses, zones, entry table, distance unit and response.
`default_nettype none
module opm_dp
   import opm_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int MAX_ZONES   = MAX_ZONES_DEF,
   parameter int ROBOT_SLOTS = ROBOT_SLOTS_DEF,
   localparam int IDX_W = $clog2(MAX_ENTRIES),
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
   localparam int RB_W  = $clog2(ROBOT_SLOTS),
   localparam int ZN_W  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   input  wire logic [IDX_W-1:0] rd_addr,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [CNT_W-1:0] total_val,
   input  wire logic [RB_W-1:0]  robot_sel,
   input  wire logic [2:0]       rsp_code,
   output      stat_type         stat,
   output      logic [CNT_W-1:0] total,
   input  wire logic [2:0]       req_mode,
   input  wire logic [15:0]      req_pos_x,
   input  wire logic [15:0]      req_pos_y,
   input  wire logic [15:0]      req_corner_x,
   input  wire logic [15:0]      req_corner_y,
   input  wire logic [2:0]       req_robot_index,
   input  wire logic [2:0]       req_zone_index,
   input  wire logic [31:0]      req_time_now,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_data,
   output      logic [2:0]       rsp_status,
   output      logic [6:0]       rsp_entry_count,
   output      logic             rsp_bounds_valid,
   output      logic [16:0]      rsp_bound_min_x,
   output      logic [16:0]      rsp_bound_min_y,
   output      logic [16:0]      rsp_bound_max_x,
   output      logic [16:0]      rsp_bound_max_y
);

   logic [2:0]  self_ff;
   logic [15:0] life_ff;
   logic [10:0] margin_ff;
   logic [3:0]  zcnt_ff;
   logic [9:0]  dup_ff;
   logic [9:0]  rob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_ff   <= SELF_ID_RST;
         life_ff   <= LIFESPAN_RST;
         margin_ff <= MARGIN_RST;
         zcnt_ff   <= ZONES_RST;
         dup_ff    <= DUP_RAD_RST;
         rob_ff    <= ROB_RAD_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_SELF_ID:  self_ff   <= csr_data[2:0];
            REG_LIFESPAN: life_ff   <= csr_data;
            REG_MARGIN:   margin_ff <= csr_data[10:0];
            REG_ZONES:    zcnt_ff   <= csr_data[3:0];
            REG_DUP_RAD:  dup_ff    <= csr_data[9:0];
            REG_ROB_RAD:  rob_ff    <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // Squared radii, refreshed every cycle from the registers.
   logic [19:0] dup2_ff, rob2_ff;
   logic [19:0] dup2_in, rob2_in;
   assign dup2_in = dup_ff * dup_ff;
   assign rob2_in = rob_ff * rob_ff;
   always_ff @(posedge clock) begin
      dup2_ff <= dup2_in;
      rob2_ff <= rob2_in;
   end

   // Latched request.
   logic [2:0]         mode_ff;
   logic signed [15:0] px_ff, py_ff, cx_ff, cy_ff;
   logic [2:0]         ridx_ff, zidx_ff;
   logic [31:0]        now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         cx_ff   <= req_corner_x;
         cy_ff   <= req_corner_y;
         ridx_ff <= req_robot_index;
         zidx_ff <= req_zone_index;
         now_ff  <= req_time_now;
      end
   end

   // Robot poses and ignore zones.
   logic signed [15:0] pose_x_ff [ROBOT_SLOTS];
   logic signed [15:0] pose_y_ff [ROBOT_SLOTS];
   logic signed [15:0] zmnx_ff [MAX_ZONES];
   logic signed [15:0] zmny_ff [MAX_ZONES];
   logic signed [15:0] zmxx_ff [MAX_ZONES];
   logic signed [15:0] zmxy_ff [MAX_ZONES];
   logic [2:0]         ridx_m1;
   logic               pose_ok, zone_ok;

   assign ridx_m1 = ridx_ff - 3'd1;
   assign pose_ok = (ridx_ff != 3'd0) && (int'(ridx_ff) <= ROBOT_SLOTS);
   assign zone_ok = int'(zidx_ff) < MAX_ZONES;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROBOT_SLOTS; r++) begin
            pose_x_ff[r] <= '0;
            pose_y_ff[r] <= '0;
         end
         for (int z = 0; z < MAX_ZONES; z++) begin
            zmnx_ff[z] <= '0;
            zmny_ff[z] <= '0;
            zmxx_ff[z] <= '0;
            zmxy_ff[z] <= '0;
         end
      end else if (cmd.exec) begin
         if (mode_ff == MODE_POSE && pose_ok) begin
            pose_x_ff[RB_W'(ridx_m1)] <= px_ff;
            pose_y_ff[RB_W'(ridx_m1)] <= py_ff;
         end
         if (mode_ff == MODE_ZONE && zone_ok) begin
            zmnx_ff[ZN_W'(zidx_ff)] <= (px_ff < cx_ff) ? px_ff : cx_ff;
            zmxx_ff[ZN_W'(zidx_ff)] <= (px_ff < cx_ff) ? cx_ff : px_ff;
            zmny_ff[ZN_W'(zidx_ff)] <= (py_ff < cy_ff) ? py_ff : cy_ff;
            zmxy_ff[ZN_W'(zidx_ff)] <= (py_ff < cy_ff) ? cy_ff : py_ff;
         end
      end
   end

   logic zone_hit;

   always_comb begin
      zone_hit = 1'b0;
      for (int z = 0; z < MAX_ZONES; z++) begin
         if (z < int'(zcnt_ff) && px_ff >= zmnx_ff[z] && px_ff <= zmxx_ff[z] &&
             py_ff >= zmny_ff[z] && py_ff <= zmxy_ff[z])
            zone_hit = 1'b1;
      end
   end
   assign stat.zone_hit = zone_hit;

   // Entry table with registered read.
   entry_type mem [MAX_ENTRIES];
   entry_type rd_ff;
   entry_type wdata;

   always_comb begin
      case (cmd.wr_src)
         WR_REFRESH: wdata = '{x: rd_ff.x, y: rd_ff.y, seen: now_ff};
         WR_COPY:    wdata = rd_ff;
         default:    wdata = '{x: px_ff, y: py_ff, seen: now_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we)
         mem[wr_addr] <= wdata;
      if (cmd.mem_rd)
         rd_ff <= mem[rd_addr];
   end

   // Shared distance unit: squares registered, then sum and compare.
   logic signed [15:0] bx, by;
   logic signed [16:0] dx, dy;
   logic signed [33:0] prod_x, prod_y;
   logic [31:0]        sqx_ff, sqy_ff;
   logic               skip_ff, skip_in;
   logic [32:0]        sum;

   assign bx      = cmd.sq_mem ? signed'(rd_ff.x) : pose_x_ff[robot_sel];
   assign by      = cmd.sq_mem ? signed'(rd_ff.y) : pose_y_ff[robot_sel];
   assign dx      = 17'(px_ff) - 17'(bx);
   assign dy      = 17'(py_ff) - 17'(by);
   assign prod_x  = dx * dx;
   assign prod_y  = dy * dy;
   assign skip_in = (int'(robot_sel) + 1 == int'(self_ff)) ||
                    (pose_x_ff[robot_sel] == 16'sd0 && pose_y_ff[robot_sel] == 16'sd0);

   always_ff @(posedge clock) begin
      if (cmd.sq_go) begin
         sqx_ff  <= prod_x[31:0];
         sqy_ff  <= prod_y[31:0];
         skip_ff <= skip_in;
      end
   end

   assign sum          = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign stat.near    = !skip_ff && (sum < {13'd0, rob2_ff});
   assign stat.dup_hit = sum < {13'd0, dup2_ff};

   logic [31:0] age;
   assign age       = now_ff - rd_ff.seen;
   assign stat.keep = age <= {16'd0, life_ff};

   // Entry count.
   logic [CNT_W-1:0] total_ff;
   always_ff @(posedge clock) begin
      if (reset)
         total_ff <= '0;
      else if (cmd.set_total)
         total_ff <= total_val;
      else if (cmd.append)
         total_ff <= total_ff + CNT_W'(1);
   end
   assign total = total_ff;

   // Bounding box over kept entries.
   logic               any_ff;
   logic signed [16:0] bmnx_ff, bmny_ff, bmxx_ff, bmxy_ff;
   logic signed [16:0] lx, ly, hx, hy;

   assign lx = 17'(signed'(rd_ff.x)) - signed'({6'd0, margin_ff});
   assign ly = 17'(signed'(rd_ff.y)) - signed'({6'd0, margin_ff});
   assign hx = 17'(signed'(rd_ff.x)) + signed'({6'd0, margin_ff});
   assign hy = 17'(signed'(rd_ff.y)) + signed'({6'd0, margin_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
      end else if (cmd.bounds_clr) begin
         any_ff <= 1'b0;
      end else if (cmd.bounds_upd) begin
         any_ff <= 1'b1;
         if (!any_ff || lx < bmnx_ff) bmnx_ff <= lx;
         if (!any_ff || ly < bmny_ff) bmny_ff <= ly;
         if (!any_ff || hx > bmxx_ff) bmxx_ff <= hx;
         if (!any_ff || hy > bmxy_ff) bmxy_ff <= hy;
      end
   end

   // Response register.
   logic show;
   assign show = (mode_ff == MODE_EXPIRE) && any_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status       <= rsp_code;
         rsp_entry_count  <= 7'(total_ff);
         rsp_bounds_valid <= show;
         rsp_bound_min_x  <= show ? bmnx_ff : '0;
         rsp_bound_min_y  <= show ? bmny_ff : '0;
         rsp_bound_max_x  <= show ? bmxx_ff : '0;
         rsp_bound_max_y  <= show ? bmxy_ff : '0;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/opm_ctrl.sv
// Controller: sequences checks, table walks and the response handshake.
`default_nettype none
module opm_ctrl
   import opm_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int ROBOT_SLOTS = ROBOT_SLOTS_DEF,
   localparam int IDX_W = $clog2(MAX_ENTRIES),
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
   localparam int RB_W  = $clog2(ROBOT_SLOTS)
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire logic [2:0]       req_mode,
   input  wire stat_type         stat,
   input  wire logic [CNT_W-1:0] total,
   output      cmd_type          cmd,
   output      logic [IDX_W-1:0] rd_addr,
   output      logic [IDX_W-1:0] wr_addr,
   output      logic [CNT_W-1:0] total_val,
   output      logic [RB_W-1:0]  robot_sel,
   output      logic [2:0]       rsp_code
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ZONE = 4'd1;
   localparam logic [3:0] S_RSQ  = 4'd2;
   localparam logic [3:0] S_RCMP = 4'd3;
   localparam logic [3:0] S_DRD  = 4'd4;
   localparam logic [3:0] S_DSQ  = 4'd5;
   localparam logic [3:0] S_DCMP = 4'd6;
   localparam logic [3:0] S_APP  = 4'd7;
   localparam logic [3:0] S_EXEC = 4'd8;
   localparam logic [3:0] S_ERD  = 4'd9;
   localparam logic [3:0] S_ECHK = 4'd10;
   localparam logic [3:0] S_FIN  = 4'd11;
   localparam logic [3:0] S_RESP = 4'd12;

   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic [RB_W-1:0]  robot_ff, robot_in;
   logic [2:0]       code_ff, code_in;
   logic             last;
   logic             accept;

   assign last      = (CNT_W'(idx_ff) + CNT_W'(1)) == total;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;
   assign accept    = req_valid && req_ready;
   assign rd_addr   = idx_ff;
   assign robot_sel = robot_ff;
   assign rsp_code  = code_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      kept_in   = kept_ff;
      robot_in  = robot_ff;
      code_in   = code_ff;
      cmd       = '0;
      wr_addr   = idx_ff;
      total_val = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load       = 1'b1;
               cmd.bounds_clr = 1'b1;
               idx_in         = '0;
               kept_in        = '0;
               robot_in       = '0;
               code_in        = ST_DONE;
               case (req_mode)
                  MODE_DETECT: state_in = S_ZONE;
                  MODE_EXPIRE: begin
                     code_in = ST_BOUNDS;
                     if (total == '0) state_in = S_FIN;
                     else state_in = S_ERD;
                  end
                  MODE_CLEAR: begin
                     cmd.set_total = 1'b1;
                     state_in      = S_FIN;
                  end
                  default: state_in = S_EXEC;
               endcase
            end
         end
         S_ZONE: begin
            if (stat.zone_hit) begin
               code_in  = ST_IN_ZONE;
               state_in = S_FIN;
            end else begin
               state_in = S_RSQ;
            end
         end
         S_RSQ: begin
            cmd.sq_go = 1'b1;
            state_in  = S_RCMP;
         end
         S_RCMP: begin
            if (stat.near) begin
               code_in  = ST_NEAR;
               state_in = S_FIN;
            end else if (int'(robot_ff) == ROBOT_SLOTS - 1) begin
               if (total == '0) state_in = S_APP;
               else state_in = S_DRD;
            end else begin
               robot_in = robot_ff + RB_W'(1);
               state_in = S_RSQ;
            end
         end
         S_DRD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_DSQ;
         end
         S_DSQ: begin
            cmd.sq_go  = 1'b1;
            cmd.sq_mem = 1'b1;
            state_in   = S_DCMP;
         end
         S_DCMP: begin
            if (stat.dup_hit) begin
               cmd.mem_we = 1'b1;
               cmd.wr_src = WR_REFRESH;
               code_in    = ST_REFRESH;
               state_in   = S_FIN;
            end else if (last) begin
               state_in = S_APP;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_DRD;
            end
         end
         S_APP: begin
            if (int'(total) >= MAX_ENTRIES) begin
               code_in = ST_FULL;
            end else begin
               cmd.mem_we = 1'b1;
               cmd.wr_src = WR_ITEM;
               cmd.append = 1'b1;
               wr_addr    = total[IDX_W-1:0];
               code_in    = ST_STORED;
            end
            state_in = S_FIN;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_FIN;
         end
         S_ERD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_ECHK;
         end
         S_ECHK: begin
            wr_addr = kept_ff[IDX_W-1:0];
            if (stat.keep) begin
               cmd.mem_we     = 1'b1;
               cmd.wr_src     = WR_COPY;
               cmd.bounds_upd = 1'b1;
               kept_in        = kept_ff + CNT_W'(1);
            end
            if (last) begin
               cmd.set_total = 1'b1;
               total_val     = kept_in;
               state_in      = S_FIN;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_ERD;
            end
         end
         S_FIN: begin
            cmd.rsp_load = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         kept_ff  <= '0;
         robot_ff <= '0;
         code_ff  <= ST_DONE;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         kept_ff  <= kept_in;
         robot_ff <= robot_in;
         code_ff  <= code_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/obstacle_point_memory.sv
// Top level of the obstacle point memory: controller, datapath and channels.
// A detection runs a zone check, a square and a compare step per robot slot, then a read,
// square and compare step per table entry searched for duplicates; a zone hit ends it.
// An expiry sweep reads and checks each entry; pose and zone writes have an execute step.
// One request is in flight at a time; the next is taken the cycle after the response leaves.
// Synchronous active-high reset empties the table and restores register defaults.
`default_nettype none
module obstacle_point_memory
   import opm_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int MAX_ZONES   = MAX_ZONES_DEF,
   parameter int ROBOT_SLOTS = ROBOT_SLOTS_DEF
)(
   input wire logic clock,
   input wire logic reset,
   opm_req_if.sink   req_bus,
   opm_rsp_if.source rsp_bus,
   opm_csr_if.sink   csr_bus
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int RB_W  = $clog2(ROBOT_SLOTS);

   cmd_type          cmd;
   stat_type         stat;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [CNT_W-1:0] total_val, total;
   logic [RB_W-1:0]  robot_sel;
   logic [2:0]       rsp_code;

   // Register writes are always taken; the user must send them only while idle, unchecked.
   assign csr_bus.ready = 1'b1;

   // The controller walks one request at a time: zone check, each robot slot with a square
   // and a compare step, then the table, one entry per read of the table.
   opm_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ROBOT_SLOTS (ROBOT_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .req_mode  (req_bus.mode),
      .stat      (stat),
      .total     (total),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .total_val (total_val),
      .robot_sel (robot_sel),
      .rsp_code  (rsp_code)
   );

   // The datapath holds every stored value and the registered response.
   opm_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_ZONES   (MAX_ZONES),
      .ROBOT_SLOTS (ROBOT_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .total_val        (total_val),
      .robot_sel        (robot_sel),
      .rsp_code         (rsp_code),
      .stat             (stat),
      .total            (total),
      .req_mode         (req_bus.mode),
      .req_pos_x        (req_bus.pos_x),
      .req_pos_y        (req_bus.pos_y),
      .req_corner_x     (req_bus.corner_x),
      .req_corner_y     (req_bus.corner_y),
      .req_robot_index  (req_bus.robot_index),
      .req_zone_index   (req_bus.zone_index),
      .req_time_now     (req_bus.time_now),
      .csr_we           (csr_bus.valid && csr_bus.ready),
      .csr_index        (csr_bus.index),
      .csr_data         (csr_bus.data),
      .rsp_status       (rsp_bus.status),
      .rsp_entry_count  (rsp_bus.entry_count),
      .rsp_bounds_valid (rsp_bus.bounds_valid),
      .rsp_bound_min_x  (rsp_bus.bound_min_x),
      .rsp_bound_min_y  (rsp_bus.bound_min_y),
      .rsp_bound_max_x  (rsp_bus.bound_max_x),
      .rsp_bound_max_y  (rsp_bus.bound_max_y)
   );

endmodule
`default_nettype wire

FILE: bench/obstacle_point_memory_tb.sv
// Self-checking testbench for the obstacle point memory: directed and random requests.
module obstacle_point_memory_tb
   import opm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] corner_x;
      logic [15:0] corner_y;
      logic [2:0]  robot_index;
      logic [2:0]  zone_index;
      logic [31:0] time_now;
   } request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  entry_count;
      logic        bounds_valid;
      logic [16:0] bound_min_x;
      logic [16:0] bound_min_y;
      logic [16:0] bound_max_x;
      logic [16:0] bound_max_y;
   } response_type;

   localparam int REQ_BITS = $bits(request_type);

   // Behavioral copy of the point table, its settings and the queue of
   // responses it predicts.
   class point_table_model;
      logic [2:0]  self_id;
      logic [15:0] lifespan;
      logic [10:0] margin;
      logic [3:0]  zones;
      logic [9:0]  dup_rad;
      logic [9:0]  rob_rad;
      int          ex[MAX_ENTRIES_DEF];
      int          ey[MAX_ENTRIES_DEF];
      logic [31:0] eseen[MAX_ENTRIES_DEF];
      int          total;
      int          rx[ROBOT_SLOTS_DEF];
      int          ry[ROBOT_SLOTS_DEF];
      int          zlx[MAX_ZONES_DEF], zly[MAX_ZONES_DEF];
      int          zhx[MAX_ZONES_DEF], zhy[MAX_ZONES_DEF];
      response_type pending[$];
      int          errors;
      int          checked;
      int          bounds_seen;

      function new();
         self_id = SELF_ID_RST;
         lifespan = LIFESPAN_RST;
         margin = MARGIN_RST;
         zones = ZONES_RST;
         dup_rad = DUP_RAD_RST;
         rob_rad = ROB_RAD_RST;
         total = 0;
         errors = 0;
         checked = 0;
         bounds_seen = 0;
         foreach (rx[i]) begin
            rx[i] = 0;
            ry[i] = 0;
         end
         foreach (zlx[i]) begin
            zlx[i] = 0;
            zly[i] = 0;
            zhx[i] = 0;
            zhy[i] = 0;
         end
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] data);
         case (idx)
            REG_SELF_ID:  self_id = data[2:0];
            REG_LIFESPAN: lifespan = data;
            REG_MARGIN:   margin = data[10:0];
            REG_ZONES:    zones = data[3:0];
            REG_DUP_RAD:  dup_rad = data[9:0];
            REG_ROB_RAD:  rob_rad = data[9:0];
            default: ;
         endcase
      endfunction

      function longint sq_dist(int ax, int ay, int bx, int by);
         longint dx, dy;
         dx = ax - bx;
         dy = ay - by;
         return dx * dx + dy * dy;
      endfunction

      // Works out the response to one accepted request and updates the table.
      function void note_request(request_type r);
         response_type rsp;
         int px, py, cx, cy, n, lx, ly, hx, hy, kept, m;
         bit hit;
         logic [31:0] age;
         px = $signed(r.pos_x);
         py = $signed(r.pos_y);
         cx = $signed(r.corner_x);
         cy = $signed(r.corner_y);
         rsp = '0;
         rsp.status = ST_DONE;
         case (r.mode)
            MODE_DETECT: begin
               hit = 0;
               n = (zones > MAX_ZONES_DEF) ? MAX_ZONES_DEF : zones;
               for (int i = 0; i < n; i++)
                  if (px >= zlx[i] && px <= zhx[i] && py >= zly[i] && py <= zhy[i])
                     hit = 1;
               if (hit) begin
                  rsp.status = ST_IN_ZONE;
               end else begin
                  for (int i = 0; i < ROBOT_SLOTS_DEF; i++)
                     if (i + 1 != self_id && !(rx[i] == 0 && ry[i] == 0) &&
                         sq_dist(px, py, rx[i], ry[i]) < longint'(rob_rad) * rob_rad)
                        hit = 1;
                  if (hit) begin
                     rsp.status = ST_NEAR;
                  end else begin
                     for (int i = 0; i < total && !hit; i++)
                        if (sq_dist(px, py, ex[i], ey[i]) < longint'(dup_rad) * dup_rad) begin
                           eseen[i] = r.time_now;
                           hit = 1;
                        end
                     if (hit) begin
                        rsp.status = ST_REFRESH;
                     end else if (total < MAX_ENTRIES_DEF) begin
                        ex[total] = px;
                        ey[total] = py;
                        eseen[total] = r.time_now;
                        total++;
                        rsp.status = ST_STORED;
                     end else begin
                        rsp.status = ST_FULL;
                     end
                  end
               end
            end
            MODE_POSE: begin
               if (r.robot_index >= 1 && r.robot_index <= ROBOT_SLOTS_DEF) begin
                  rx[r.robot_index - 1] = px;
                  ry[r.robot_index - 1] = py;
               end
            end
            MODE_ZONE: begin
               if (r.zone_index < MAX_ZONES_DEF) begin
                  zlx[r.zone_index] = (px < cx) ? px : cx;
                  zhx[r.zone_index] = (px < cx) ? cx : px;
                  zly[r.zone_index] = (py < cy) ? py : cy;
                  zhy[r.zone_index] = (py < cy) ? cy : py;
               end
            end
            MODE_EXPIRE: begin
               kept = 0;
               m = margin;
               for (int i = 0; i < total; i++) begin
                  age = r.time_now - eseen[i];
                  if (age <= {16'd0, lifespan}) begin
                     ex[kept] = ex[i];
                     ey[kept] = ey[i];
                     eseen[kept] = eseen[i];
                     kept++;
                  end
               end
               total = kept;
               lx = 0; ly = 0; hx = 0; hy = 0;
               for (int i = 0; i < kept; i++) begin
                  if (i == 0 || ex[i] - m < lx) lx = ex[i] - m;
                  if (i == 0 || ey[i] - m < ly) ly = ey[i] - m;
                  if (i == 0 || ex[i] + m > hx) hx = ex[i] + m;
                  if (i == 0 || ey[i] + m > hy) hy = ey[i] + m;
               end
               rsp.status = ST_BOUNDS;
               rsp.bounds_valid = kept > 0;
               rsp.bound_min_x = lx[16:0];
               rsp.bound_min_y = ly[16:0];
               rsp.bound_max_x = hx[16:0];
               rsp.bound_max_y = hy[16:0];
               if (kept > 0) bounds_seen++;
            end
            MODE_CLEAR: total = 0;
            default: ;
         endcase
         rsp.entry_count = total[6:0];
         pending.insert(pending.size(), rsp);
      endfunction

      function void check_response(response_type got);
         response_type want;
         checked++;
         if (pending.size() == 0) begin
            $display("%t: response with none expected: %p", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) report("status", want.status, got.status);
         if (got.entry_count !== want.entry_count)
            report("entry_count", want.entry_count, got.entry_count);
         if (got.bounds_valid !== want.bounds_valid)
            report("bounds_valid", want.bounds_valid, got.bounds_valid);
         if (got.bound_min_x !== want.bound_min_x)
            report("bound_min_x", want.bound_min_x, got.bound_min_x);
         if (got.bound_min_y !== want.bound_min_y)
            report("bound_min_y", want.bound_min_y, got.bound_min_y);
         if (got.bound_max_x !== want.bound_max_x)
            report("bound_max_x", want.bound_max_x, got.bound_max_x);
         if (got.bound_max_y !== want.bound_max_y)
            report("bound_max_y", want.bound_max_y, got.bound_max_y);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         $display("%t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
         errors++;
      endfunction
   endclass

   logic clock;
   logic reset;

   opm_req_if req_bus();
   opm_rsp_if rsp_bus();
   opm_csr_if csr_bus();

   obstacle_point_memory dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   point_table_model points = new();

   // Idle percentages of the two sides, changed between phases.
   int  send_idle_pct;
   int  recv_idle_pct;
   int  cycle_count = 0;
   int  sent;
   // Detection time base; advances slowly so that expiry sees a mix of ages.
   logic [31:0] clock_ms;

   localparam int CYCLE_LIMIT = 1500000;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: stalls at random and checks every accepted response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            points.check_response({rsp_bus.status, rsp_bus.entry_count, rsp_bus.bounds_valid,
                                   rsp_bus.bound_min_x, rsp_bus.bound_min_y,
                                   rsp_bus.bound_max_x, rsp_bus.bound_max_y});
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Sends one request and waits for it to be accepted; the model sees it then.
   // Valid stays high after acceptance until the next request or an idle cycle.
   task automatic send_request(request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= r.mode;
      req_bus.pos_x       <= r.pos_x;
      req_bus.pos_y       <= r.pos_y;
      req_bus.corner_x    <= r.corner_x;
      req_bus.corner_y    <= r.corner_y;
      req_bus.robot_index <= r.robot_index;
      req_bus.zone_index  <= r.zone_index;
      req_bus.time_now    <= r.time_now;
      do @(posedge clock); while (!req_bus.ready);
      points.note_request(r);
      sent++;
   endtask

   // Register writes happen only with nothing outstanding.
   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      points.write_reg(idx, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (points.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic request_type make_req(logic [2:0] mode, int x, int y, int cx = 0,
                                            int cy = 0, int ridx = 1, int zidx = 0,
                                            logic [31:0] now = 0);
      request_type r;
      r.mode = mode;
      r.pos_x = x[15:0];
      r.pos_y = y[15:0];
      r.corner_x = cx[15:0];
      r.corner_y = cy[15:0];
      r.robot_index = ridx[2:0];
      r.zone_index = zidx[2:0];
      r.time_now = now;
      return r;
   endfunction

   // Random request. Detections cluster around a few hot spots so that
   // refreshes, near-robot drops and zone hits all happen often.
   function automatic request_type random_req();
      request_type r;
      int pick, cxp, cyp;
      r = request_type'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom}));
      pick = $urandom_range(99);
      cxp = ($urandom_range(3) * 600) - 900;
      cyp = ($urandom_range(3) * 600) - 900;
      clock_ms = clock_ms + $urandom_range(400);
      r.time_now = clock_ms;
      if (pick < 60) begin
         r.mode = MODE_DETECT;
         if ($urandom_range(9) != 0) begin
            r.pos_x = 16'(cxp + $urandom_range(400) - 200);
            r.pos_y = 16'(cyp + $urandom_range(400) - 200);
         end
         if ($urandom_range(19) == 0) r.time_now = $urandom;
      end else if (pick < 68) begin
         r.mode = MODE_POSE;
         r.robot_index = 3'($urandom_range(7));
         if ($urandom_range(3) != 0) begin
            r.pos_x = 16'(cxp);
            r.pos_y = 16'(cyp);
         end else if ($urandom_range(3) == 0) begin
            r.pos_x = '0;
            r.pos_y = '0;
         end
      end else if (pick < 76) begin
         r.mode = MODE_ZONE;
         if ($urandom_range(3) != 0) begin
            r.pos_x = 16'(cxp - 150);
            r.pos_y = 16'(cyp - 150);
            r.corner_x = 16'(cxp + $urandom_range(300) - 150);
            r.corner_y = 16'(cyp + $urandom_range(300) - 150);
         end
      end else if (pick < 92) begin
         r.mode = MODE_EXPIRE;
         if ($urandom_range(9) == 0) r.time_now = $urandom;
      end else if (pick < 96) begin
         r.mode = MODE_CLEAR;
      end else begin
         r.mode = 3'($urandom_range(7, 5));
      end
      return r;
   endfunction

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_DETECT;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.corner_x = '0;
      req_bus.corner_y = '0;
      req_bus.robot_index = '0;
      req_bus.zone_index = '0;
      req_bus.time_now = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_SELF_ID;
      csr_bus.data = '0;
      sent = 0;
      clock_ms = 32'd1000;
      send_idle_pct = 17;
      recv_idle_pct = 57;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset settings: extremes of coordinates,
      // a robot drop, a refresh, out-of-range slots and unknown modes.
      send_request(make_req(MODE_DETECT, -32768, 32767, 0, 0, 1, 0, 32'd10));
      send_request(make_req(MODE_DETECT, 32767, -32768, 0, 0, 1, 0, 32'hFFFF_FFFF));
      send_request(make_req(MODE_DETECT, 32767 - 10, -32768 + 10, 0, 0, 1, 0, 32'd20));
      send_request(make_req(MODE_DETECT, 0, 0, 0, 0, 1, 0, 32'd30));
      send_request(make_req(MODE_POSE, 500, 500, 0, 0, 2));
      send_request(make_req(MODE_POSE, 0, 0, 0, 0, 0));
      send_request(make_req(MODE_POSE, 9, 9, 0, 0, 7));
      send_request(make_req(MODE_POSE, 300, 300, 0, 0, 1));
      send_request(make_req(MODE_DETECT, 560, 500, 0, 0, 1, 0, 32'd40));
      send_request(make_req(MODE_DETECT, 300, 310, 0, 0, 1, 0, 32'd40));
      send_request(make_req(MODE_ZONE, 1000, -1000, -1000, 1000, 1, 0));
      send_request(make_req(MODE_ZONE, -32768, -32768, 32767, 32767, 1, 7));
      send_request(make_req(MODE_DETECT, 1000, 1000, 0, 0, 1, 0, 32'd50));
      send_request(make_req(MODE_EXPIRE, 0, 0, 0, 0, 1, 0, 32'd2000));
      send_request(make_req(MODE_EXPIRE, 0, 0, 0, 0, 1, 0, 32'd5040));
      send_request(make_req(3'd5, 0, 0));
      send_request(make_req(3'd7, 0, 0));
      send_request(make_req(MODE_CLEAR, 0, 0));
      send_request(make_req(MODE_EXPIRE, 0, 0, 0, 0, 1, 0, 32'd7));
      drain();

      // Zones on, self id out of range, extreme radii and margin.
      write_reg(REG_ZONES, 16'd1);
      write_reg(REG_SELF_ID, 16'd0);
      write_reg(REG_DUP_RAD, 16'd1000);
      write_reg(REG_ROB_RAD, 16'd1000);
      write_reg(REG_MARGIN, 16'd2000);
      write_reg(REG_LIFESPAN, 16'd0);
      send_request(make_req(MODE_DETECT, 0, 0, 0, 0, 1, 0, 32'd100));
      send_request(make_req(MODE_POSE, 0, 0, 0, 0, 2));
      send_request(make_req(MODE_POSE, 0, 0, 0, 0, 1));
      send_request(make_req(MODE_ZONE, 0, 0, 0, 0, 1, 0));
      send_request(make_req(MODE_DETECT, -32768, -32768, 0, 0, 1, 0, 32'd100));
      send_request(make_req(MODE_EXPIRE, 0, 0, 0, 0, 1, 0, 32'd100));
      drain();

      // Random phases, each with its own settings and idling pattern;
      // the pause to drain between phases covers the full-sender pause too.
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 57;
            recv_idle_pct = 17;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_reg(REG_SELF_ID, 16'($urandom_range(5)));
         write_reg(REG_LIFESPAN, (phase == 1) ? 16'hFFFF : 16'($urandom_range(6000, 500)));
         write_reg(REG_MARGIN, (phase == 3) ? 16'd0 : 16'($urandom_range(2047)));
         write_reg(REG_ZONES, (phase == 5) ? 16'd15 : 16'($urandom_range(8)));
         write_reg(REG_DUP_RAD, (phase == 0) ? 16'd0 : 16'($urandom_range(1023)));
         write_reg(REG_ROB_RAD, (phase == 2) ? 16'd0 : 16'($urandom_range(1023)));
         for (int k = 0; k < 190; k++) send_request(random_req());
         drain();
      end

      $display("Sent %0d requests, checked %0d responses, %0d non-empty bounds reports.",
               sent, points.checked, points.bounds_seen);
      if (points.errors == 0 && points.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
